// ----- rtl/ctt_pkg.sv -----
`default_nettype none

package ctt_pkg;

  // Fixed field widths of one request and one result.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned GEN_W   = 5;
  localparam int unsigned PAY_W   = 48;

  // Replacement score is depth minus age times eight, held as a signed value.
  localparam int unsigned AGE_SHIFT = 3;
  localparam int unsigned SCORE_W   = DEPTH_W + 2;

  // Key bits consumed per cycle by the iterative cluster index unit.
  localparam int unsigned DIGIT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INDEX,
    S_EVAL,
    S_WIPE,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic rd_en;
    logic eval_fire;
    logic wipe;
    logic clr_gen;
    logic out_load;
    logic out_zero;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_done;
    logic wipe_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ctt_ram.sv -----
`default_nettype none

module ctt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/ctt_idx.sv -----
`default_nettype none

module ctt_idx #(
  parameter int unsigned NUM_CLUSTERS = 1024,
  localparam int unsigned IDX_W = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ctt_pkg::KEY_W-1:0] key_i,
  output logic                           done_o,
  output logic      [IDX_W-1:0]          idx_o
);

  import ctt_pkg::*;

  localparam bit POW2 = ((NUM_CLUSTERS & (NUM_CLUSTERS - 1)) == 0);

  logic             done_q;
  logic [IDX_W-1:0] idx_q;

  if (POW2) begin : g_mask
    // The cluster is simply the low key bits.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        idx_q <= (NUM_CLUSTERS == 1) ? '0 : key_i[IDX_W-1:0];
      end
    end
  end else begin : g_iter
    localparam int unsigned STEPS = KEY_W / DIGIT_W;
    localparam int unsigned CNT_W = $clog2(STEPS);
    localparam logic [IDX_W:0] NCL = (IDX_W + 1)'(NUM_CLUSTERS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic             busy_q;
    logic [CNT_W-1:0] cnt_q;
    logic [KEY_W-1:0] key_q;
    logic [IDX_W-1:0] rem_d;

    // Restoring remainder, most significant key bits first, a few bits a cycle.
    always_comb begin
      logic [IDX_W:0]   t;
      logic [IDX_W-1:0] r;
      r = idx_q;
      for (int j = 0; j < DIGIT_W; j++) begin
        t = {r, key_q[KEY_W-1-j]};
        if (t >= NCL) begin
          r = IDX_W'(t - NCL);
        end else begin
          r = t[IDX_W-1:0];
        end
      end
      rem_d = r;
    end

    // Step control.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else if (busy_q) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == LAST) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    // Key shift register and running remainder.
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
        idx_q <= '0;
      end else if (busy_q) begin
        key_q <= key_q << DIGIT_W;
        idx_q <= rem_d;
      end
    end
  end

  assign done_o = done_q;
  assign idx_o  = idx_q;

endmodule

`default_nettype wire

// ----- rtl/ctt_ctrl.sv -----
`default_nettype none

module ctt_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [ctt_pkg::OP_W-1:0] in_op_i,
  output logic                          in_ready_o,
  input  wire ctt_pkg::sts_t            sts_i,
  output ctt_pkg::cmd_t                 cmd_o
);

  import ctt_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // A request may enter when idle, or as the previous result is placed.
  always_comb begin
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_EVAL:  in_ready_o = sts_i.out_free;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (sts_i.wipe_last) state_d = S_IDLE;
      end
      S_IDLE, S_EVAL: begin
        if (state_q == S_EVAL && !sts_i.out_free) begin
          state_d = S_EVAL;
        end else if (accept) begin
          unique case (op_e'(in_op_i))
            OP_PROBE, OP_STORE: state_d = S_INDEX;
            OP_CLEAR:           state_d = S_WIPE;
            default:            state_d = S_RESP;
          endcase
        end else begin
          state_d = S_IDLE;
        end
      end
      S_INDEX: begin
        if (sts_i.idx_done) state_d = S_EVAL;
      end
      S_WIPE: begin
        if (sts_i.wipe_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.in_load   = accept;
    cmd_o.clr_gen   = accept && (op_e'(in_op_i) == OP_CLEAR);
    cmd_o.rd_en     = (state_q == S_INDEX) && sts_i.idx_done;
    cmd_o.eval_fire = (state_q == S_EVAL) && sts_i.out_free;
    cmd_o.wipe      = (state_q == S_INIT) || (state_q == S_WIPE);
    cmd_o.out_zero  = (state_q == S_RESP);
    cmd_o.out_load  = cmd_o.eval_fire || ((state_q == S_RESP) && sts_i.out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ctt_dp.sv -----
`default_nettype none

module ctt_dp #(
  parameter int unsigned NUM_CLUSTERS = 1024,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned PAYLOAD_BITS = 48,
  localparam int unsigned IDX_W = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ctt_pkg::cmd_t               cmd_i,
  output ctt_pkg::sts_t                    sts_o,
  input  wire logic [ctt_pkg::OP_W-1:0]    op_i,
  input  wire logic [ctt_pkg::KEY_W-1:0]   key_i,
  input  wire logic [ctt_pkg::DEPTH_W-1:0] depth_i,
  input  wire logic [ctt_pkg::PAY_W-1:0]   entry_payload_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic [ctt_pkg::GEN_W-1:0]   cfg_data_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic                             hit_o,
  output logic      [ctt_pkg::DEPTH_W-1:0] hit_depth_o,
  output logic      [ctt_pkg::GEN_W-1:0]   hit_generation_o,
  output logic      [ctt_pkg::PAY_W-1:0]   hit_payload_o
);

  import ctt_pkg::*;

  localparam int unsigned ENTRY_W = TAG_W + DEPTH_W + GEN_W + PAYLOAD_BITS;
  localparam int unsigned ROW_W   = WAYS * ENTRY_W;
  localparam int unsigned WAY_W   = $clog2(WAYS);
  localparam int unsigned GEN_LSB = PAYLOAD_BITS;
  localparam int unsigned DEP_LSB = PAYLOAD_BITS + GEN_W;
  localparam int unsigned TAG_LSB = PAYLOAD_BITS + GEN_W + DEPTH_W;
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(NUM_CLUSTERS - 1);

  // Captured request.
  op_e                     op_q;
  logic [TAG_W-1:0]        tag_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [GEN_W-1:0]        gen_q;

  logic             idx_done;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] wcnt_q;
  logic             wipe_last;

  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_new;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic             wr_en;

  logic [TAG_W-1:0]         w_tag   [WAYS];
  logic [DEPTH_W-1:0]       w_depth [WAYS];
  logic [GEN_W-1:0]         w_gen   [WAYS];
  logic [PAYLOAD_BITS-1:0]  w_pay   [WAYS];
  logic signed [SCORE_W-1:0] w_score [WAYS];

  logic                    hit_any;
  logic [WAY_W-1:0]        hit_way;
  logic [DEPTH_W-1:0]      hit_dep;
  logic [GEN_W-1:0]        hit_gen;
  logic [PAYLOAD_BITS-1:0] hit_pay;
  logic [WAY_W-1:0]        vict_way;
  logic [WAY_W-1:0]        sel_way;
  logic                    do_wr;
  logic [ENTRY_W-1:0]      new_ent;

  logic                    out_valid_q;
  logic                    hit_q;
  logic [DEPTH_W-1:0]      hit_dep_q;
  logic [GEN_W-1:0]        hit_gen_q;
  logic [PAYLOAD_BITS-1:0] hit_pay_q;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q    <= op_e'(op_i);
      tag_q   <= key_i[TAG_W-1:0];
      depth_q <= depth_i;
      pay_q   <= entry_payload_i[PAYLOAD_BITS-1:0];
    end
  end

  // Current generation; a clear request sets it back to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cmd_i.clr_gen) begin
      gen_q <= '0;
    end else if (cfg_valid_i) begin
      gen_q <= cfg_data_i;
    end
  end

  // Cluster index from the key.
  ctt_idx #(
    .NUM_CLUSTERS(NUM_CLUSTERS)
  ) u_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.in_load),
    .key_i  (key_i),
    .done_o (idx_done),
    .idx_o  (idx)
  );

  // Row counter for the clearing pass.
  assign wipe_last = (wcnt_q == LAST_ROW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
    end else if (cmd_i.wipe) begin
      wcnt_q <= wipe_last ? '0 : wcnt_q + IDX_W'(1);
    end
  end

  // One row holds every way of a cluster.
  assign ram_we    = cmd_i.wipe || wr_en;
  assign ram_waddr = cmd_i.wipe ? wcnt_q : idx;
  assign ram_wdata = cmd_i.wipe ? '0 : row_new;

  ctt_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_CLUSTERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx),
    .rdata_o(row)
  );

  // Split the row into ways and score each for replacement.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      w_tag[w]   = row[w*ENTRY_W + TAG_LSB +: TAG_W];
      w_depth[w] = row[w*ENTRY_W + DEP_LSB +: DEPTH_W];
      w_gen[w]   = row[w*ENTRY_W + GEN_LSB +: GEN_W];
      w_pay[w]   = row[w*ENTRY_W +: PAYLOAD_BITS];
      w_score[w] = $signed({2'b00, w_depth[w]})
                 - $signed({2'b00, GEN_W'(gen_q - w_gen[w]), AGE_SHIFT'(0)});
    end
  end

  // First matching way, in way order.
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    hit_dep = '0;
    hit_gen = '0;
    hit_pay = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && (w_tag[w] == tag_q)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
        hit_dep = w_depth[w];
        hit_gen = w_gen[w];
        hit_pay = w_pay[w];
      end
    end
  end

  // Lowest score wins the replacement; the lower way wins a tie.
  always_comb begin
    logic signed [SCORE_W-1:0] best;
    best     = w_score[0];
    vict_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (w_score[w] < best) begin
        best     = w_score[w];
        vict_way = WAY_W'(w);
      end
    end
  end

  // Store: update a matching way only with a deeper entry, else evict.
  assign sel_way = hit_any ? hit_way : vict_way;
  assign do_wr   = (op_q == OP_STORE) && (!hit_any || (depth_q > hit_dep));
  assign wr_en   = cmd_i.eval_fire && do_wr;
  assign new_ent = {tag_q, depth_q, gen_q, pay_q};

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_new[w*ENTRY_W +: ENTRY_W] = (WAY_W'(w) == sel_way) ? new_ent
                                                           : row[w*ENTRY_W +: ENTRY_W];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_zero || (op_q != OP_PROBE)) begin
        hit_q     <= 1'b0;
        hit_dep_q <= '0;
        hit_gen_q <= '0;
        hit_pay_q <= '0;
      end else begin
        hit_q     <= hit_any;
        hit_dep_q <= hit_dep;
        hit_gen_q <= hit_gen;
        hit_pay_q <= hit_pay;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign hit_depth_o      = hit_dep_q;
  assign hit_generation_o = hit_gen_q;
  assign hit_payload_o    = PAY_W'(hit_pay_q);

  // Status to the controller.
  assign sts_o.idx_done  = idx_done;
  assign sts_o.wipe_last = wipe_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ----- rtl/clustered_transposition_table.sv -----
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    op_i, key_i, depth_i, entry_payload_i
// out      out_valid_o / out_ready_i  hit_o, hit_depth_o, hit_generation_o, hit_payload_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_data_i (current generation)
//
// When NUM_CLUSTERS is a power of two a probe or store request passes through
// an index state that issues the row read, then a compare and write-back state.
// Otherwise the cluster index is found four key bits a cycle over the whole key.
// After reset, and for a clear request, the row memory is swept one row a cycle
// over all NUM_CLUSTERS rows, during which no request is taken; config is always taken.
// A probe or store whose result cannot yet enter the output register waits in compare.
`default_nettype none

module clustered_transposition_table #(
  parameter int unsigned NUM_CLUSTERS = 1024,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned PAYLOAD_BITS = 48
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ctt_pkg::OP_W-1:0]    op_i,
  input  wire logic [ctt_pkg::KEY_W-1:0]   key_i,
  input  wire logic [ctt_pkg::DEPTH_W-1:0] depth_i,
  input  wire logic [ctt_pkg::PAY_W-1:0]   entry_payload_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             hit_o,
  output logic      [ctt_pkg::DEPTH_W-1:0] hit_depth_o,
  output logic      [ctt_pkg::GEN_W-1:0]   hit_generation_o,
  output logic      [ctt_pkg::PAY_W-1:0]   hit_payload_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ctt_pkg::GEN_W-1:0]   cfg_data_i
);

  import ctt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The generation register takes a write in any cycle, but a clear accepted in the same cycle wins.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  ctt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (op_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Index unit, row memory, compare and replacement logic.
  ctt_dp #(
    .NUM_CLUSTERS(NUM_CLUSTERS),
    .WAYS        (WAYS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .key_i           (key_i),
    .depth_i         (depth_i),
    .entry_payload_i (entry_payload_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .hit_o           (hit_o),
    .hit_depth_o     (hit_depth_o),
    .hit_generation_o(hit_generation_o),
    .hit_payload_o   (hit_payload_o)
  );

`ifndef SYNTHESIS
  // No request is taken while the memory is being swept.
  a_no_accept_in_wipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wipe |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  // A result is never loaded over one that has not been taken.
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // One request at a time: an accepted request blocks the next cycle.
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request accepted back to back");

  // A row read never coincides with the clearing pass.
  a_read_not_in_wipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd_en && cmd.wipe))
    else $error("row read during clearing pass");
`endif

endmodule

`default_nettype wire
